>>> src/pgf_pkg.sv
// pgf_pkg: shared types and constants of the process grid factorizer
// holds the port word structs, register indexes and controller/datapath links
// no dependencies
package pgf_pkg;

  localparam int unsigned REG_W     = 11;  // config register and grid factor width
  localparam int unsigned EXT_W     = 20;  // extent field width
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_GRID_X   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_GRID_Y   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_GRID_Z   = 4'd3;

  // divider: one extra bit of headroom, four quotient bits per cycle
  localparam int unsigned DIV_W     = REG_W + 1;
  localparam int unsigned DIV_STEP  = 4;
  localparam int unsigned DIV_CYC   = DIV_W / DIV_STEP;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_CYC + 1);

  typedef struct packed {
    logic             three_dim;
    logic [EXT_W-1:0] size_x;
    logic [EXT_W-1:0] size_y;
    logic [EXT_W-1:0] size_z;
  } pgf_item_t;

  typedef struct packed {
    logic             found;
    logic [REG_W-1:0] grid_x;
    logic [REG_W-1:0] grid_y;
    logic [REG_W-1:0] grid_z;
  } pgf_result_t;

  typedef struct packed {
    logic [REG_W-1:0] process_count;
    logic [REG_W-1:0] user_grid_x;
    logic [REG_W-1:0] user_grid_y;
    logic [REG_W-1:0] user_grid_z;
  } pgf_cfg_t;

  typedef struct packed {
    logic       load;       // latch the word, reset the search
    logic       prod;       // extent pair product, index k
    logic       sum;        // bound sum
    logic       bnd_mul;    // bound sum times process count
    logic       bnd_set;    // best starts at twice that
    logic       div_start;
    logic       div_y;      // divide x quotient by py instead of count by px
    logic       x_take;     // keep count / px
    logic       y_first;    // py back to 1
    logic       take_2d;    // py from quotient, pz is 1
    logic       take_pz;    // pz from quotient
    logic       mac;        // cost term k
    logic       mac_clr;
    logic       cmp;        // compare cost with best, keep if lower
    logic       px_inc;
    logic       py_inc;
    logic [1:0] k;
  } pgf_cmd_t;

  typedef struct packed {
    logic div_done;
    logic x_ok;
    logic y2_ok;
    logic y3_ok;
    logic px_last;
    logic py_last;
    logic p_zero;
    logic three;
  } pgf_stat_t;

endpackage

>>> src/pgf_div.sv
// pgf_div: iterative unsigned divider for grid factor trials
// restoring algorithm, DIV_STEP quotient bits per cycle; uses pgf_pkg
module pgf_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pgf_pkg::REG_W-1:0] dividend_i,
  input  logic [pgf_pkg::REG_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [pgf_pkg::REG_W-1:0] quot_o,
  output logic                      rem_zero_o
);
  import pgf_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [DIV_W-1:0]     r_q, r_d;
  logic [DIV_W-1:0]     q_q, q_d;
  logic [DIV_W-1:0]     d_q;
  logic [DIV_W-1:0]     r_step, q_step;

  always_comb begin
    r_step = r_q;
    q_step = q_q;
    for (int i = 0; i < int'(DIV_STEP); i++) begin
      r_step = {r_step[DIV_W-2:0], q_step[DIV_W-1]};
      q_step = {q_step[DIV_W-2:0], 1'b0};
      if (r_step >= d_q) begin
        r_step    = r_step - d_q;
        q_step[0] = 1'b1;
      end
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    done_d = done_q;
    r_d    = r_q;
    q_d    = q_q;
    if (start_i) begin
      cnt_d  = DIV_CNT_W'(DIV_CYC);
      done_d = 1'b0;
      r_d    = '0;
      q_d    = DIV_W'(dividend_i);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      r_d   = r_step;
      q_d   = q_step;
      if (cnt_q == DIV_CNT_W'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    q_q <= q_d;
    if (start_i) begin
      d_q <= DIV_W'(divisor_i);
    end
  end

  assign done_o     = done_q;
  assign quot_o     = q_q[REG_W-1:0];
  assign rem_zero_o = (r_q == '0);

endmodule

>>> src/pgf_datapath.sv
// pgf_datapath: operand registers, products, cost accumulator and best grid
// driven by pgf_ctrl commands; uses pgf_pkg and pgf_div
module pgf_datapath #(
  parameter int unsigned MAX_PROCS   = 1024,
  parameter int unsigned EXTENT_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pgf_pkg::pgf_cmd_t    cmd_i,
  input  pgf_pkg::pgf_item_t   item_i,
  input  pgf_pkg::pgf_cfg_t    cfg_i,
  output pgf_pkg::pgf_stat_t   stat_o,
  output pgf_pkg::pgf_result_t result_o
);
  import pgf_pkg::*;

  localparam int unsigned EW = (EXTENT_BITS < EXT_W) ? EXTENT_BITS : EXT_W;
  localparam int unsigned AW = 2 * EW + 2;        // product sums
  localparam int unsigned MW = AW + REG_W;        // scaled cost
  localparam int unsigned CW = MW + 1;            // doubled bound

  function automatic logic pin_ok(input logic [REG_W-1:0] pin, input logic [REG_W-1:0] v);
    return (pin == '0) || (pin == v);
  endfunction

  logic              three_q;
  logic [EW-1:0]     sx_q, sy_q, sz_q;
  logic [2*EW-1:0]   a0_q, a1_q, a2_q;
  logic [AW-1:0]     bsum_q;
  logic [REG_W-1:0]  p_q, px_q, py_q, pz_q, xq_q;
  logic [MW-1:0]     prod_q;
  logic [CW-1:0]     acc_q, best_q;
  logic              found_q;
  logic [REG_W-1:0]  bx_q, by_q, bz_q;

  logic [EW-1:0]     ea, eb;
  logic [AW-1:0]     mul_a;
  logic [REG_W-1:0]  mul_b;
  logic              p_bad;

  logic              div_done, div_rem_zero;
  logic [REG_W-1:0]  div_quot;

  pgf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_y ? xq_q : p_q),
    .divisor_i  (cmd_i.div_y ? py_q : px_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_zero_o (div_rem_zero)
  );

  assign p_bad = (cfg_i.process_count == '0) ||
                 (32'(cfg_i.process_count) > 32'(MAX_PROCS));

  // extent pair for the area products
  always_comb begin
    ea = '0;
    eb = '0;
    case (cmd_i.k)
      2'd0: begin
        ea = sx_q;
        eb = sy_q;
      end
      2'd1: begin
        ea = sx_q;
        eb = sz_q;
      end
      2'd2: begin
        ea = sy_q;
        eb = sz_q;
      end
      default: begin
      end
    endcase
  end

  // cost term or bound operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.bnd_mul) begin
      mul_a = bsum_q;
      mul_b = p_q;
    end else if (three_q) begin
      case (cmd_i.k)
        2'd0: begin
          mul_a = AW'(a0_q);
          mul_b = pz_q;
        end
        2'd1: begin
          mul_a = AW'(a1_q);
          mul_b = py_q;
        end
        2'd2: begin
          mul_a = AW'(a2_q);
          mul_b = px_q;
        end
        default: begin
        end
      endcase
    end else begin
      case (cmd_i.k)
        2'd0: begin
          mul_a = AW'(sx_q);
          mul_b = py_q;
        end
        2'd1: begin
          mul_a = AW'(sy_q);
          mul_b = px_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      three_q <= item_i.three_dim;
      sx_q    <= item_i.size_x[EW-1:0];
      sy_q    <= item_i.size_y[EW-1:0];
      sz_q    <= item_i.size_z[EW-1:0];
      p_q     <= p_bad ? '0 : cfg_i.process_count;
      px_q    <= REG_W'(1);
      found_q <= 1'b0;
      bx_q    <= '0;
      by_q    <= '0;
      bz_q    <= '0;
    end
    if (cmd_i.prod) begin
      case (cmd_i.k)
        2'd0:    a0_q <= (2*EW)'(ea * eb);
        2'd1:    a1_q <= (2*EW)'(ea * eb);
        default: a2_q <= (2*EW)'(ea * eb);
      endcase
    end
    if (cmd_i.sum) begin
      bsum_q <= three_q ? (AW'(a0_q) + AW'(a1_q) + AW'(a2_q)) : (AW'(sx_q) + AW'(sy_q));
    end
    if (cmd_i.bnd_mul || cmd_i.mac) begin
      prod_q <= MW'(mul_a * mul_b);
    end
    if (cmd_i.bnd_set) begin
      best_q <= {prod_q, 1'b0};
    end
    if (cmd_i.x_take) begin
      xq_q <= div_quot;
    end
    if (cmd_i.y_first) begin
      py_q <= REG_W'(1);
    end
    if (cmd_i.take_2d) begin
      py_q <= div_quot;
      pz_q <= REG_W'(1);
    end
    if (cmd_i.take_pz) begin
      pz_q <= div_quot;
    end
    if (cmd_i.mac) begin
      // product register holds the term of the previous index
      acc_q <= cmd_i.mac_clr ? '0 : acc_q + CW'(prod_q);
    end
    if (cmd_i.cmp && (acc_q < best_q)) begin
      found_q <= 1'b1;
      best_q  <= acc_q;
      bx_q    <= px_q;
      by_q    <= py_q;
      bz_q    <= pz_q;
    end
    if (cmd_i.px_inc) begin
      px_q <= px_q + 1'b1;
    end
    if (cmd_i.py_inc) begin
      py_q <= py_q + 1'b1;
    end
  end

  assign stat_o.div_done = div_done;
  assign stat_o.x_ok     = div_rem_zero && pin_ok(cfg_i.user_grid_x, px_q);
  assign stat_o.y2_ok    = pin_ok(cfg_i.user_grid_y, div_quot);
  assign stat_o.y3_ok    = div_rem_zero && pin_ok(cfg_i.user_grid_y, py_q) &&
                           pin_ok(cfg_i.user_grid_z, div_quot);
  assign stat_o.px_last  = (px_q == p_q);
  assign stat_o.py_last  = (py_q == xq_q);
  assign stat_o.p_zero   = (p_q == '0);
  assign stat_o.three    = three_q;

  assign result_o.found  = found_q;
  assign result_o.grid_x = bx_q;
  assign result_o.grid_y = by_q;
  assign result_o.grid_z = bz_q;

endmodule

>>> src/pgf_ctrl.sv
// pgf_ctrl: sequencer for the factor search loops
// issues pgf_cmd_t to the datapath and reads pgf_stat_t back; uses pgf_pkg
module pgf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  pgf_pkg::pgf_stat_t stat_i,
  output pgf_pkg::pgf_cmd_t  cmd_o,
  output logic               busy_o,
  output logic               done_o
);
  import pgf_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PROD   = 4'd1;
  localparam logic [3:0] S_SUM    = 4'd2;
  localparam logic [3:0] S_BMUL   = 4'd3;
  localparam logic [3:0] S_BSET   = 4'd4;
  localparam logic [3:0] S_XSTART = 4'd5;
  localparam logic [3:0] S_XDIV   = 4'd6;
  localparam logic [3:0] S_XCHK   = 4'd7;
  localparam logic [3:0] S_YSTART = 4'd8;
  localparam logic [3:0] S_YDIV   = 4'd9;
  localparam logic [3:0] S_YCHK   = 4'd10;
  localparam logic [3:0] S_MAC    = 4'd11;
  localparam logic [3:0] S_CMP    = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  localparam logic [1:0] K_LAST_PROD = 2'd2;
  localparam logic [1:0] K_LAST_2D   = 2'd2;
  localparam logic [1:0] K_LAST_3D   = 2'd3;

  logic [3:0] state_q, state_d;
  logic [1:0] k_q, k_d;
  logic       adv_x, adv_y;

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    cmd_o     = '0;
    cmd_o.k   = k_q;
    adv_x     = 1'b0;
    adv_y     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          k_d        = '0;
          state_d    = S_PROD;
        end
      end
      S_PROD: begin
        cmd_o.prod = 1'b1;
        if (k_q == K_LAST_PROD) begin
          k_d     = '0;
          state_d = S_SUM;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_BMUL;
      end
      S_BMUL: begin
        cmd_o.bnd_mul = 1'b1;
        state_d       = S_BSET;
      end
      S_BSET: begin
        cmd_o.bnd_set = 1'b1;
        state_d       = stat_i.p_zero ? S_DONE : S_XSTART;
      end
      S_XSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_XDIV;
      end
      S_XDIV: begin
        if (stat_i.div_done) begin
          state_d = S_XCHK;
        end
      end
      S_XCHK: begin
        if (!stat_i.x_ok) begin
          adv_x = 1'b1;
        end else begin
          cmd_o.x_take = 1'b1;
          if (stat_i.three) begin
            cmd_o.y_first = 1'b1;
            state_d       = S_YSTART;
          end else if (stat_i.y2_ok) begin
            cmd_o.take_2d = 1'b1;
            k_d           = '0;
            state_d       = S_MAC;
          end else begin
            adv_x = 1'b1;
          end
        end
      end
      S_YSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_y     = 1'b1;
        state_d         = S_YDIV;
      end
      S_YDIV: begin
        if (stat_i.div_done) begin
          state_d = S_YCHK;
        end
      end
      S_YCHK: begin
        if (stat_i.y3_ok) begin
          cmd_o.take_pz = 1'b1;
          k_d           = '0;
          state_d       = S_MAC;
        end else begin
          adv_y = 1'b1;
        end
      end
      S_MAC: begin
        cmd_o.mac     = 1'b1;
        cmd_o.mac_clr = (k_q == '0);
        if (k_q == (stat_i.three ? K_LAST_3D : K_LAST_2D)) begin
          state_d = S_CMP;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        if (stat_i.three) begin
          adv_y = 1'b1;
        end else begin
          adv_x = 1'b1;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // inner loop runs out into the outer one
    if (adv_y) begin
      if (stat_i.py_last) begin
        adv_x = 1'b1;
      end else begin
        cmd_o.py_inc = 1'b1;
        state_d      = S_YSTART;
      end
    end
    if (adv_x) begin
      if (stat_i.px_last) begin
        state_d = S_DONE;
      end else begin
        cmd_o.px_inc = 1'b1;
        state_d      = S_XSTART;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

>>> src/process_grid_factorizer.sv
// process_grid_factorizer: top level, config registers, controller and datapath
// uses pgf_pkg, pgf_ctrl, pgf_datapath
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-------------------------------
//   command  | in        | start, busy               | item_i (pgf_item_t)
//   result   | out       | done_o, one-cycle strobe  | result_o (pgf_result_t)
//   config   | in        | cfg_valid, cfg_ready      | cfg_index_i, cfg_data_i
//
// one word at a time: busy rises after start and drops after the done_o cycle.
// the search runs setup, then a trial for each x factor (1 to P), a trial for each y
// factor in 3D (1 to P/px per dividing px), a cost pass per admissible grid, then done;
// every divisibility test uses the 4-bit-per-cycle divider.
// asynchronous active-low reset; config registers reset to count 1, pins free.
// the receiver cannot stall: each result is shown for its single done_o cycle.
module process_grid_factorizer #(
  parameter int unsigned MAX_PROCS   = 1024,
  parameter int unsigned EXTENT_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  pgf_pkg::pgf_item_t            item_i,
  output logic                          done_o,
  output pgf_pkg::pgf_result_t          result_o,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pgf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pgf_pkg::REG_W-1:0]     cfg_data_i
);
  import pgf_pkg::*;

  pgf_cfg_t  cfg_q;
  pgf_cmd_t  cmd;
  pgf_stat_t stat;
  logic      ctrl_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.process_count <= REG_W'(1);
      cfg_q.user_grid_x   <= '0;
      cfg_q.user_grid_y   <= '0;
      cfg_q.user_grid_z   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_i)
        CFG_PROCESS_COUNT: cfg_q.process_count <= cfg_data_i;
        CFG_USER_GRID_X:   cfg_q.user_grid_x   <= cfg_data_i;
        CFG_USER_GRID_Y:   cfg_q.user_grid_y   <= cfg_data_i;
        CFG_USER_GRID_Z:   cfg_q.user_grid_z   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  pgf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start && !ctrl_busy),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (ctrl_busy),
    .done_o  (done_o)
  );

  pgf_datapath #(
    .MAX_PROCS   (MAX_PROCS),
    .EXTENT_BITS (EXTENT_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .cfg_i    (cfg_q),
    .stat_o   (stat),
    .result_o (result_o)
  );

  assign busy = ctrl_busy;

`ifndef SYNTH
  a_done_in_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside a busy period");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted word did not start a search");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.found) |->
      (result_o.grid_x == '0 && result_o.grid_y == '0 && result_o.grid_z == '0))
    else $error("grid reported without a find");

  a_hit_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.found) |->
      (result_o.grid_x != '0 && result_o.grid_y != '0 && result_o.grid_z != '0))
    else $error("found grid has a zero factor");
`endif

endmodule

>>> sim/tb_process_grid_factorizer.sv
// tb_process_grid_factorizer: self-checking bench for the process grid factorizer
// predicts the smallest-boundary grid per word and checks every done_o strobe
// depends on pgf_pkg and process_grid_factorizer
module tb_process_grid_factorizer;
  timeunit 1ns;
  timeprecision 1ps;

  import pgf_pkg::*;

  localparam int unsigned MAX_PROCS    = 1024;
  localparam int unsigned EXTENT_BITS  = 20;
  localparam int unsigned STALL_LIMIT  = 200000;
  localparam int unsigned TAIL_CYCLES  = 64;
  localparam int unsigned RANDOM_ITEMS = 80;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 4'd15;
  localparam logic [EXT_W-1:0]     EXT_MAX      = '1;

  class grid_ledger;
    pgf_cfg_t    regs;
    pgf_result_t grids_due[$];
    int unsigned errors;

    function new();
      regs = '0;
      regs.process_count = REG_W'(1);
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      case (idx)
        CFG_PROCESS_COUNT: regs.process_count = val;
        CFG_USER_GRID_X:   regs.user_grid_x   = val;
        CFG_USER_GRID_Y:   regs.user_grid_y   = val;
        CFG_USER_GRID_Z:   regs.user_grid_z   = val;
        default: ;
      endcase
    endfunction

    function bit pin_ok(logic [REG_W-1:0] pin, int unsigned v);
      return pin == 0 || pin == v;
    endfunction

    // costs are scaled by the process count so every compare is exact
    function pgf_result_t min_boundary_grid(pgf_item_t w);
      longint unsigned sx, sy, sz, a0, a1, a2, best, cost;
      int unsigned     p, px, py, pz, rem;
      pgf_result_t     r;
      sx = w.size_x;
      sy = w.size_y;
      sz = w.size_z;
      p  = regs.process_count;
      r  = '0;
      if (p == 0 || p > MAX_PROCS) p = 0;
      if (!w.three_dim) begin
        best = 64'd2 * p * (sx + sy);
        for (px = 1; px <= p; px++) begin
          if (p % px == 0 && pin_ok(regs.user_grid_x, px)) begin
            py = p / px;
            if (pin_ok(regs.user_grid_y, py)) begin
              cost = sx * py + sy * px;
              if (cost < best) begin
                best = cost;
                r.found  = 1'b1;
                r.grid_x = REG_W'(px);
                r.grid_y = REG_W'(py);
                r.grid_z = REG_W'(1);
              end
            end
          end
        end
      end else begin
        a0 = sx * sy;
        a1 = sx * sz;
        a2 = sy * sz;
        best = 64'd2 * p * (a0 + a1 + a2);
        for (px = 1; px <= p; px++) begin
          if (p % px == 0 && pin_ok(regs.user_grid_x, px)) begin
            rem = p / px;
            for (py = 1; py <= rem; py++) begin
              if (rem % py == 0 && pin_ok(regs.user_grid_y, py)) begin
                pz = rem / py;
                if (pin_ok(regs.user_grid_z, pz)) begin
                  cost = a0 * pz + a1 * py + a2 * px;
                  if (cost < best) begin
                    best = cost;
                    r.found  = 1'b1;
                    r.grid_x = REG_W'(px);
                    r.grid_y = REG_W'(py);
                    r.grid_z = REG_W'(pz);
                  end
                end
              end
            end
          end
        end
      end
      return r;
    endfunction

    function void note_item(pgf_item_t w);
      grids_due.push_back(min_boundary_grid(w));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(pgf_result_t got);
      pgf_result_t want;
      if (grids_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual found=%0d grid=%0d/%0d/%0d",
                 $time, got.found, got.grid_x, got.grid_y, got.grid_z);
      end else begin
        want = grids_due.pop_front();
        compare_field("found", want.found, got.found);
        compare_field("grid_x", want.grid_x, got.grid_x);
        compare_field("grid_y", want.grid_y, got.grid_y);
        compare_field("grid_z", want.grid_z, got.grid_z);
      end
    endfunction

    function int unsigned pending();
      return grids_due.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  pgf_item_t            item_i;
  logic                 done_o;
  pgf_result_t          result_o;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [REG_W-1:0]     cfg_data_i;

  grid_ledger  ledger = new();
  pgf_item_t   batch_q[$];
  int unsigned idle_pct;

  process_grid_factorizer #(
    .MAX_PROCS  (MAX_PROCS),
    .EXTENT_BITS(EXTENT_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) ledger.check_result(result_o);
  end

  // ends the run when nothing moves on any channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || done_o || (start && !busy) || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic void push_word(bit three, logic [EXT_W-1:0] sx, logic [EXT_W-1:0] sy,
                                    logic [EXT_W-1:0] sz);
    pgf_item_t w;
    w.three_dim = three;
    w.size_x    = sx;
    w.size_y    = sy;
    w.size_z    = sz;
    batch_q.push_back(w);
  endfunction

  function automatic logic [EXT_W-1:0] rand_extent();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return $urandom_range(1) ? EXT_MAX : '0;
    if (r < 50) return EXT_W'($urandom_range(0, 255));
    return EXT_W'($urandom_range(0, 20'hFFFFF));
  endfunction

  // mostly free or a true divisor, sometimes any register value
  function automatic logic [REG_W-1:0] pick_pin(int unsigned p);
    int unsigned r, d;
    r = $urandom_range(99);
    if (r < 50) return '0;
    if (r < 85 && p != 0) begin
      repeat (64) begin
        d = $urandom_range(1, p);
        if (p % d == 0) return REG_W'(d);
      end
      return REG_W'(p);
    end
    return REG_W'($urandom_range(0, 2047));
  endfunction

  task automatic wait_drained();
    while (ledger.pending() != 0) @(posedge clk_i);
  endtask

  // all four registers plus one write to an unmapped index, block idle
  task automatic set_grid(int unsigned p, int unsigned ux, int unsigned uy, int unsigned uz);
    logic [CFG_IDX_W-1:0] idxs[5];
    logic [REG_W-1:0]     vals[5];
    wait_drained();
    idxs = '{CFG_PROCESS_COUNT, CFG_USER_GRID_X, CFG_USER_GRID_Y, CFG_USER_GRID_Z,
             CFG_UNMAPPED};
    vals = '{REG_W'(p), REG_W'(ux), REG_W'(uy), REG_W'(uz),
             REG_W'($urandom_range(0, 2047))};
    for (int i = 0; i < 5; i++) begin
      cfg_valid   <= 1'b1;
      cfg_index_i <= idxs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready);
      ledger.write_reg(idxs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // start is re-decided every cycle, so gaps land anywhere in the search
  task automatic drive_batch();
    while (batch_q.size() != 0) begin
      item_i <= batch_q[0];
      start  <= ($urandom_range(99) >= idle_pct);
      forever begin
        @(posedge clk_i);
        if (start && !busy) break;
        start <= ($urandom_range(99) >= idle_pct);
      end
      ledger.note_item(batch_q.pop_front());
    end
    start <= 1'b0;
  endtask

  initial begin
    int unsigned sent, n, p, sel;
    bit          heavy;
    start       <= 1'b0;
    item_i      <= '0;
    cfg_valid   <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_pct = 20;

    // reset settings: one process
    push_word(1'b0, '0, '0, '0);
    push_word(1'b0, EXT_MAX, EXT_MAX, EXT_MAX);
    push_word(1'b1, EXT_MAX, EXT_MAX, EXT_MAX);
    push_word(1'b1, 20'd5, '0, '0);
    drive_batch();

    // ties keep the first grid
    set_grid(2, 0, 0, 0);
    push_word(1'b0, 20'd7, 20'd7, '0);
    push_word(1'b1, 20'd9, 20'd9, 20'd9);
    drive_batch();

    // z pin ignored in 2d, non-dividing z pin in 3d
    set_grid(12, 3, 0, 7);
    push_word(1'b0, 20'd100, 20'd300, '0);
    push_word(1'b1, 20'd100, 20'd200, 20'd300);
    drive_batch();

    set_grid(12, 0, 5, 0);
    push_word(1'b0, 20'd1, 20'd1, '0);
    drive_batch();

    set_grid(12, 2, 3, 0);
    push_word(1'b1, 20'd30, 20'd20, 20'd10);
    drive_batch();

    // nothing to search
    set_grid(0, 0, 0, 0);
    push_word(1'b0, 20'd10, 20'd20, '0);
    push_word(1'b1, 20'd10, 20'd20, 20'd30);
    drive_batch();

    // counts beyond the search range
    set_grid(1025, 0, 0, 0);
    push_word(1'b0, 20'd3, 20'd4, '0);
    drive_batch();

    set_grid(2047, 2047, 2047, 2047);
    push_word(1'b1, EXT_MAX, 20'd1, EXT_MAX);
    drive_batch();

    set_grid(MAX_PROCS, 0, 0, 0);
    push_word(1'b0, EXT_MAX, 20'd1, '0);
    push_word(1'b1, EXT_MAX, EXT_MAX, EXT_MAX);
    drive_batch();

    set_grid(MAX_PROCS, MAX_PROCS, 1, 1);
    push_word(1'b1, 20'd1, 20'd2, 20'd3);
    push_word(1'b0, '0, 20'd5, '0);
    drive_batch();

    // one zero extent pushes px down to 1
    set_grid(6, 0, 0, 0);
    push_word(1'b0, '0, 20'd5, '0);
    drive_batch();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_pct = (sent < RANDOM_ITEMS / 3) ? 20 : (sent < 2 * RANDOM_ITEMS / 3) ? 85 : 0;
      heavy = 1'b0;
      sel = $urandom_range(99);
      if (sel < 70) begin
        p = $urandom_range(1, 64);
      end else if (sel < 80) begin
        case ($urandom_range(2))
          0: p = 0;
          1: p = $urandom_range(MAX_PROCS + 1, 2047);
          default: p = 2047;
        endcase
      end else if (sel < 90) begin
        p = $urandom_range(65, 256);
      end else begin
        heavy = 1'b1;
        p = $urandom_range(1) ? MAX_PROCS : $urandom_range(512, MAX_PROCS);
      end
      set_grid(p, pick_pin(p), pick_pin(p), pick_pin(p));
      n = heavy ? 2 : $urandom_range(3, 8);
      repeat (n) push_word(1'($urandom_range(1)), rand_extent(), rand_extent(), rand_extent());
      drive_batch();
      sent += n;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
